/* rtl/wpcr_pkg.sv */
package wpcr_pkg;

   localparam logic [2:0] OP_PIN_CHANGE   = 3'd0;
   localparam logic [2:0] OP_TICK         = 3'd1;
   localparam logic [2:0] OP_BUS_BYTE     = 3'd2;
   localparam logic [2:0] OP_STOP         = 3'd3;
   localparam logic [2:0] OP_DIRECTION    = 3'd4;
   localparam logic [2:0] OP_ENERGY       = 3'd5;

   localparam logic [7:0] CLEAR_BYTE      = 8'h52;
   localparam logic [7:0] PAST_END_BYTE   = 8'hFF;

   localparam logic [3:0] RECORD_LEN      = 4'd13;
   localparam logic [3:0] CHECKSUM_POS    = 4'd12;

   typedef struct packed {
      logic [2:0]  operation;
      logic        wind_pin_low;
      logic        rain_pin_low;
      logic [7:0]  bus_byte;
      logic [15:0] direction_value;
      logic [31:0] energy_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rain_total;
      logic [15:0] wind_total;
      logic [15:0] wind_in_interval;
      logic [15:0] wind_interval_peak;
      logic [15:0] average_direction;
      logic [31:0] energy_word;
      logic [3:0]  read_position;
   } state_type;

endpackage

/* rtl/wpcr_channels.sv */
interface wpcr_req_if;
   logic             valid;
   logic             ready;
   wpcr_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wpcr_rsp_if;
   logic             valid;
   logic             ready;
   wpcr_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/weather_pulse_counter_readout_top.sv */
// Flow: an accepted item is held in the input register, and its result is then
//    registered in the result register before it is offered on rsp_chan.
// Throughput: one item per cycle while results are taken; while a result waits,
//    an empty input register still takes an item; stalls only when both are full.
// Reset: synchronous, active high; clears all counters, the energy and direction
//    words, the record position and both pipeline valid flags.
module weather_pulse_counter_readout_top (
   input logic              clock,
   input logic              reset,
   wpcr_req_if.sink         req_chan,
   wpcr_rsp_if.source       rsp_chan
);

   logic                in_vld_ff;
   wpcr_pkg::req_type   in_data_ff;
   logic                rsp_vld_ff;
   wpcr_pkg::rsp_type   rsp_data_ff;
   wpcr_pkg::rsp_type   rsp_data_in;
   wpcr_pkg::state_type st_ff;
   wpcr_pkg::state_type st_in;
   logic                advance;
   logic                process;
   logic [7:0]          record_byte;

   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign process        = in_vld_ff && advance;
   assign req_chan.ready = !in_vld_ff || advance;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

   wpcr_record u_record (
      .state       (st_ff),
      .position    (st_ff.read_position),
      .record_byte (record_byte)
   );

   always_comb begin
      st_in                = st_ff;
      rsp_data_in.tx_byte  = 8'd0;
      rsp_data_in.tx_valid = 1'b0;
      unique case (in_data_ff.operation)
         wpcr_pkg::OP_PIN_CHANGE: begin
            if (in_data_ff.wind_pin_low) begin
               st_in.wind_total       = st_ff.wind_total + 16'd1;
               st_in.wind_in_interval = st_ff.wind_in_interval + 16'd1;
            end
            if (in_data_ff.rain_pin_low) begin
               st_in.rain_total = st_ff.rain_total + 16'd1;
            end
         end
         wpcr_pkg::OP_TICK: begin
            if (st_ff.wind_interval_peak < st_ff.wind_in_interval) begin
               st_in.wind_interval_peak = st_ff.wind_in_interval;
            end
            st_in.wind_in_interval = 16'd0;
         end
         wpcr_pkg::OP_BUS_BYTE: begin
            if (in_data_ff.bus_byte == wpcr_pkg::CLEAR_BYTE) begin
               st_in.rain_total         = 16'd0;
               st_in.wind_total         = 16'd0;
               st_in.wind_in_interval   = 16'd0;
               st_in.wind_interval_peak = 16'd0;
               st_in.energy_word        = 32'd0;
            end else begin
               rsp_data_in.tx_byte  = record_byte;
               rsp_data_in.tx_valid = 1'b1;
               if (st_ff.read_position < wpcr_pkg::RECORD_LEN) begin
                  st_in.read_position = st_ff.read_position + 4'd1;
               end
            end
         end
         wpcr_pkg::OP_STOP: begin
            st_in.read_position = 4'd0;
         end
         wpcr_pkg::OP_DIRECTION: begin
            st_in.average_direction = in_data_ff.direction_value;
         end
         wpcr_pkg::OP_ENERGY: begin
            st_in.energy_word = in_data_ff.energy_bits;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         st_ff      <= '0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_vld_ff <= in_vld_ff;
         end
         if (process) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.data;
      end
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.read_position <= wpcr_pkg::RECORD_LEN)
      else $error("record position past end");

   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_data_ff.tx_valid |-> rsp_data_ff.tx_byte == 8'd0)
      else $error("non-read item carries a byte");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("stalled input item lost");

   a_stop_rewind: assert property (@(posedge clock) disable iff (reset)
      process && in_data_ff.operation == wpcr_pkg::OP_STOP |=> st_ff.read_position == 4'd0)
      else $error("stop did not rewind record");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_vld_ff)
      else $error("processed item gave no result");

endmodule

/* rtl/wpcr_record.sv */
module wpcr_record (
   input  wpcr_pkg::state_type state,
   input  logic [3:0]          position,
   output logic [7:0]          record_byte
);

   localparam logic [3:0] CHECKSUM_POS_L = wpcr_pkg::CHECKSUM_POS;

   logic [7:0] bytes [12];
   logic [7:0] checksum;

   always_comb begin
      bytes[0]  = state.rain_total[7:0];
      bytes[1]  = state.rain_total[15:8];
      bytes[2]  = state.wind_total[7:0];
      bytes[3]  = state.wind_total[15:8];
      bytes[4]  = state.wind_interval_peak[7:0];
      bytes[5]  = state.wind_interval_peak[15:8];
      bytes[6]  = state.average_direction[7:0];
      bytes[7]  = state.average_direction[15:8];
      bytes[8]  = state.energy_word[7:0];
      bytes[9]  = state.energy_word[15:8];
      bytes[10] = state.energy_word[23:16];
      bytes[11] = state.energy_word[31:24];
   end

   always_comb begin
      checksum = 8'd0;
      for (int i = 0; i < 12; i++) begin
         checksum = checksum + bytes[i];
      end
   end

   always_comb begin
      if (position < CHECKSUM_POS_L) begin
         record_byte = bytes[position];
      end else if (position == CHECKSUM_POS_L) begin
         record_byte = checksum;
      end else begin
         record_byte = wpcr_pkg::PAST_END_BYTE;
      end
   end

endmodule

/* dv/weather_pulse_counter_readout_top_test.sv */
`timescale 1ns / 1ps

module weather_pulse_counter_readout_top_test;

   localparam logic [2:0] OP_SPARE_6  = 3'd6;
   localparam logic [2:0] OP_SPARE_7  = 3'd7;
   localparam int         RANDOM_ITEMS = 800;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         TAIL_CYCLES  = 8;

   typedef struct {
      wpcr_pkg::req_type item;
      int                count;
      bit                fixed;
      wpcr_pkg::rsp_type want;
   } table_row_type;

   logic clock;
   logic reset;

   wpcr_req_if req_if ();
   wpcr_rsp_if rsp_if ();

   weather_pulse_counter_readout_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [15:0] rain_pulses;
   logic [15:0] wind_pulses;
   logic [15:0] gust_count;
   logic [15:0] peak_count;
   logic [15:0] heading;
   logic [31:0] energy_reg;
   logic [3:0]  byte_index;

   wpcr_pkg::rsp_type expected_rsp[$];
   table_row_type     stim_table[$];
   int                fail_count;
   int                cycles;
   int                hold_left;
   bit                calm;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic logic [7:0] record_byte_at(logic [3:0] idx);
      logic [7:0] rec[12];
      logic [7:0] sum;
      rec[0]  = rain_pulses[7:0];
      rec[1]  = rain_pulses[15:8];
      rec[2]  = wind_pulses[7:0];
      rec[3]  = wind_pulses[15:8];
      rec[4]  = peak_count[7:0];
      rec[5]  = peak_count[15:8];
      rec[6]  = heading[7:0];
      rec[7]  = heading[15:8];
      rec[8]  = energy_reg[7:0];
      rec[9]  = energy_reg[15:8];
      rec[10] = energy_reg[23:16];
      rec[11] = energy_reg[31:24];
      sum = 8'h00;
      if (idx < wpcr_pkg::CHECKSUM_POS) return rec[idx];
      if (idx == wpcr_pkg::CHECKSUM_POS) begin
         for (int i = 0; i < 12; i++) sum = sum + rec[i];
         return sum;
      end
      return wpcr_pkg::PAST_END_BYTE;
   endfunction

   function automatic wpcr_pkg::rsp_type advance_hub(wpcr_pkg::req_type it);
      wpcr_pkg::rsp_type r;
      r.tx_byte  = 8'h00;
      r.tx_valid = 1'b0;
      case (it.operation)
         wpcr_pkg::OP_PIN_CHANGE: begin
            if (it.wind_pin_low) begin
               wind_pulses = wind_pulses + 16'd1;
               gust_count  = gust_count + 16'd1;
            end
            if (it.rain_pin_low) rain_pulses = rain_pulses + 16'd1;
         end
         wpcr_pkg::OP_TICK: begin
            if (peak_count < gust_count) peak_count = gust_count;
            gust_count = 16'd0;
         end
         wpcr_pkg::OP_BUS_BYTE: begin
            if (it.bus_byte == wpcr_pkg::CLEAR_BYTE) begin
               rain_pulses = 16'd0;
               wind_pulses = 16'd0;
               gust_count  = 16'd0;
               peak_count  = 16'd0;
               energy_reg  = 32'd0;
            end else begin
               r.tx_byte  = record_byte_at(byte_index);
               r.tx_valid = 1'b1;
               if (byte_index < wpcr_pkg::RECORD_LEN) byte_index = byte_index + 4'd1;
            end
         end
         wpcr_pkg::OP_STOP:      byte_index = 4'd0;
         wpcr_pkg::OP_DIRECTION: heading = it.direction_value;
         wpcr_pkg::OP_ENERGY:    energy_reg = it.energy_bits;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic wpcr_pkg::req_type make_item(logic [2:0] op);
      wpcr_pkg::req_type it;
      it.operation       = op;
      it.wind_pin_low    = 1'($urandom_range(0, 1));
      it.rain_pin_low    = 1'($urandom_range(0, 1));
      it.bus_byte        = 8'($urandom_range(0, 255));
      it.direction_value = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 35999));
      it.energy_bits     = $urandom;
      if (op == wpcr_pkg::OP_BUS_BYTE && it.bus_byte == wpcr_pkg::CLEAR_BYTE)
         it.bus_byte = 8'h53;
      return it;
   endfunction

   function automatic void add_row(logic [2:0] op, logic wind, logic rain, logic [7:0] rx,
                                   logic [15:0] dir, logic [31:0] nrg, int count,
                                   bit fixed, logic [7:0] want_byte, logic want_valid);
      table_row_type row;
      row.item.operation       = op;
      row.item.wind_pin_low    = wind;
      row.item.rain_pin_low    = rain;
      row.item.bus_byte        = rx;
      row.item.direction_value = dir;
      row.item.energy_bits     = nrg;
      row.count                = count;
      row.fixed                = fixed;
      row.want.tx_byte         = want_byte;
      row.want.tx_valid        = want_valid;
      stim_table.push_back(row);
   endfunction

   task automatic send_item(wpcr_pkg::req_type it, bit fixed, wpcr_pkg::rsp_type want);
      int                gap;
      wpcr_pkg::rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= it;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = advance_hub(it);
      expected_rsp.push_back(fixed ? want : predicted);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      wpcr_pkg::rsp_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp.size() == 0) begin
               note_fail($sformatf("unexpected item tx_byte=%h tx_valid=%b",
                                   rsp_if.data.tx_byte, rsp_if.data.tx_valid));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_if.data.tx_byte !== want.tx_byte)
                  note_fail($sformatf("tx_byte expected %h got %h",
                                      want.tx_byte, rsp_if.data.tx_byte));
               if (rsp_if.data.tx_valid !== want.tx_valid)
                  note_fail($sformatf("tx_valid expected %b got %b",
                                      want.tx_valid, rsp_if.data.tx_valid));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            hold_left = pick_gap();
         end
      end
   end

   initial begin
      wpcr_pkg::rsp_type none;
      wpcr_pkg::req_type it;
      int                sent;
      int                burst;
      int                r;
      none.tx_byte  = 8'h00;
      none.tx_valid = 1'b0;
      calm        = 1'b1;
      sent        = 0;
      rain_pulses = 16'd0;
      wind_pulses = 16'd0;
      gust_count  = 16'd0;
      peak_count  = 16'd0;
      heading     = 16'd0;
      energy_reg  = 32'd0;
      byte_index  = 4'd0;
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;

      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b1);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
              1, 1'b1, 8'h00, 1'b1);
      add_row(wpcr_pkg::OP_STOP, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
              1, 1'b1, 8'h00, 1'b0);
      add_row(OP_SPARE_6, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
              1, 1'b1, 8'h00, 1'b0);
      add_row(OP_SPARE_7, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_PIN_CHANGE, 1'b1, 1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
              3, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_PIN_CHANGE, 1'b1, 1'b0, 8'h00, 16'h0000, 32'h0,
              2, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_PIN_CHANGE, 1'b0, 1'b1, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_PIN_CHANGE, 1'b0, 1'b0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_TICK, 1'b1, 1'b1, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_PIN_CHANGE, 1'b1, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_TICK, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_DIRECTION, 1'b0, 1'b0, 8'h00, 16'd35999, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_DIRECTION, 1'b0, 1'b0, 8'h00, 16'hFFFF, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_ENERGY, 1'b0, 1'b0, 8'h00, 16'h0000, 32'hFFFF_FFFF,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_STOP, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h01, 16'h0000, 32'h0,
              13, 1'b0, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h53, 16'h0000, 32'h0,
              2, 1'b1, wpcr_pkg::PAST_END_BYTE, 1'b1);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, wpcr_pkg::CLEAR_BYTE, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h51, 16'h0000, 32'h0,
              1, 1'b1, wpcr_pkg::PAST_END_BYTE, 1'b1);
      add_row(wpcr_pkg::OP_STOP, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b1);
      add_row(wpcr_pkg::OP_ENERGY, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h5A5A_A5A5,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_STOP, 1'b0, 1'b0, 8'h00, 16'h0000, 32'h0,
              1, 1'b1, 8'h00, 1'b0);
      add_row(wpcr_pkg::OP_BUS_BYTE, 1'b0, 1'b0, 8'h80, 16'h0000, 32'h0,
              14, 1'b0, 8'h00, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         for (int n = 0; n < stim_table[i].count; n++)
            send_item(stim_table[i].item, stim_table[i].fixed, stim_table[i].want);

      drain_results();
      calm = 1'b0;

      while (sent < RANDOM_ITEMS) begin
         calm = (sent >= 300 && sent < 400);
         if (sent % 150 == 149) drain_results();
         r = $urandom_range(0, 99);
         if (r < 25) begin
            send_item(make_item(wpcr_pkg::OP_STOP), 1'b0, none);
            burst = $urandom_range(10, 16);
            for (int n = 0; n < burst; n++)
               send_item(make_item(wpcr_pkg::OP_BUS_BYTE), 1'b0, none);
            sent += burst + 1;
         end else begin
            if (r < 50)      it = make_item(wpcr_pkg::OP_PIN_CHANGE);
            else if (r < 57) it = make_item(wpcr_pkg::OP_TICK);
            else if (r < 67) it = make_item(wpcr_pkg::OP_BUS_BYTE);
            else if (r < 73) it = make_item(wpcr_pkg::OP_STOP);
            else if (r < 80) it = make_item(wpcr_pkg::OP_DIRECTION);
            else if (r < 87) it = make_item(wpcr_pkg::OP_ENERGY);
            else if (r < 90) begin
               it = make_item(wpcr_pkg::OP_BUS_BYTE);
               it.bus_byte = wpcr_pkg::CLEAR_BYTE;
            end else it = make_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7);
            send_item(it, 1'b0, none);
            sent++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/wpcr_pkg.sv
rtl/wpcr_channels.sv
rtl/wpcr_record.sv
rtl/weather_pulse_counter_readout_top.sv
dv/weather_pulse_counter_readout_top_test.sv
